@@ sv/ccs_pkg.sv @@
// ccs_pkg: shared types and constants for the C comment stripper.
// No dependencies; imported by every module of the block.
package ccs_pkg;

  // Marker characters
  localparam logic [7:0] CH_SLASH     = 8'h2F;
  localparam logic [7:0] CH_STAR      = 8'h2A;
  localparam logic [7:0] CH_DQUOTE    = 8'h22;
  localparam logic [7:0] CH_SQUOTE    = 8'h27;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_NEWLINE   = 8'h0A;

  // Queue between front and back
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // One queued request: a byte, optionally preceded by a held-back slash
  typedef struct packed {
    logic       pair;
    logic [7:0] data;
  } ccs_entry_t;

  // Queue status seen by front and back
  typedef struct packed {
    logic full;
    logic nonempty;
  } ccs_qstat_t;

endpackage

@@ sv/ccs_in_if.sv @@
// ccs_in_if: input channel carrying one source byte per request.
// No dependencies.
interface ccs_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

@@ sv/ccs_out_if.sv @@
// ccs_out_if: output channel carrying one comment-free byte per request.
// No dependencies.
interface ccs_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last;

  modport source (output valid, output out_byte, output last, input ready);
  modport sink   (input valid, input out_byte, input last, output ready);
endinterface

@@ sv/c_comment_stripper.sv @@
// c_comment_stripper: removes C block and line comments from a byte stream.
// Depends on ccs_pkg, ccs_in_if, ccs_out_if, ccs_front, ccs_fifo, ccs_back.
//
//   channel  dir  payload                 notes
//   din      in   in_byte[7:0]            one source byte per request
//   dout     out  out_byte[7:0], last     zero to two results per input byte
//
// One input byte is taken per cycle while the four-entry queue has room.
// A held-back slash with its follower leaves the output stage as two result bytes,
// so such input needs extra output bandwidth; the queue absorbs it.
// From input acceptance, a result passes through the queue and then the output register.
// Synchronous reset returns the scanner to code mode and empties the queue.
// Either side may stall independently; a stalled result holds in the output register.
module c_comment_stripper (
  input  logic      clk,
  input  logic      rst,
  ccs_in_if.sink    din,
  ccs_out_if.source dout
);
  import ccs_pkg::*;

  logic       q_push;
  logic       q_pop;
  ccs_entry_t q_entry;
  ccs_entry_t q_head;
  ccs_qstat_t qstat;

  ccs_front u_front (
    .clk     (clk),
    .rst     (rst),
    .din     (din),
    .qstat   (qstat),
    .q_push  (q_push),
    .q_entry (q_entry)
  );

  ccs_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (q_entry),
    .pop        (q_pop),
    .head       (q_head),
    .qstat      (qstat)
  );

  ccs_back u_back (
    .clk   (clk),
    .rst   (rst),
    .head  (q_head),
    .qstat (qstat),
    .pop   (q_pop),
    .dout  (dout)
  );

  // Queue never written when full
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !qstat.full)
    else $error("queue overflow");

  // Queue never read when empty
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> qstat.nonempty)
    else $error("queue underflow");

  // The second half of a pair follows its slash at once
  a_pair_follows: assert property (@(posedge clk) disable iff (rst)
    (dout.valid && dout.ready && !dout.last) |=> (dout.valid && dout.last))
    else $error("pair split");

  // Nothing offered straight after reset
  a_reset_clear: assert property (@(posedge clk)
    rst |=> !dout.valid)
    else $error("output valid after reset");

endmodule

@@ sv/ccs_front.sv @@
// ccs_front: lexical scanner; classifies each input byte and queues what is emitted.
// Depends on ccs_pkg and ccs_in_if.
module ccs_front (
  input  logic                clk,
  input  logic                rst,
  ccs_in_if.sink              din,
  input  ccs_pkg::ccs_qstat_t qstat,
  output logic                q_push,
  output ccs_pkg::ccs_entry_t q_entry
);
  import ccs_pkg::*;

  typedef enum logic [2:0] {
    MODE_CODE   = 3'd0,
    MODE_BLOCK  = 3'd1,
    MODE_LINE   = 3'd2,
    MODE_QUOTE  = 3'd3,
    MODE_SLASH  = 3'd4,
    MODE_STAR   = 3'd5,
    MODE_ESCAPE = 3'd6
  } mode_t;

  mode_t      mode, mode_next;
  logic       quote_dbl, quote_dbl_next;
  logic       emit;
  logic       pair;
  logic       accept;
  logic [7:0] c;
  logic [7:0] closer;
  logic       is_quote;

  assign din.ready = !qstat.full;
  assign accept    = din.valid && din.ready;
  assign c         = din.in_byte;
  assign closer    = quote_dbl ? CH_DQUOTE : CH_SQUOTE;
  assign is_quote  = (c == CH_DQUOTE) || (c == CH_SQUOTE);

  // Next mode and emit decision
  always_comb begin
    mode_next      = mode;
    quote_dbl_next = quote_dbl;
    emit           = 1'b0;
    pair           = 1'b0;
    unique case (mode)
      MODE_BLOCK: begin
        if (c == CH_STAR) mode_next = MODE_STAR;
      end
      MODE_LINE: begin
        if (c == CH_NEWLINE) begin
          mode_next = MODE_CODE;
          emit      = 1'b1;
        end
      end
      MODE_QUOTE: begin
        emit = 1'b1;
        if (c == CH_BACKSLASH) mode_next = MODE_ESCAPE;
        else if (c == closer)  mode_next = MODE_CODE;
      end
      MODE_SLASH: begin
        if (c == CH_STAR) begin
          mode_next = MODE_BLOCK;
        end else if (c == CH_SLASH) begin
          mode_next = MODE_LINE;
        end else begin
          emit = 1'b1;
          pair = 1'b1;
          if (is_quote) begin
            mode_next      = MODE_QUOTE;
            quote_dbl_next = (c == CH_DQUOTE);
          end else begin
            mode_next = MODE_CODE;
          end
        end
      end
      MODE_STAR: begin
        if (c == CH_SLASH)     mode_next = MODE_CODE;
        else if (c != CH_STAR) mode_next = MODE_BLOCK;
      end
      MODE_ESCAPE: begin
        mode_next = MODE_QUOTE;
        emit      = 1'b1;
      end
      default: begin
        // code mode, and the unreachable eighth code
        if (c == CH_SLASH) begin
          mode_next = MODE_SLASH;
        end else begin
          emit      = 1'b1;
          mode_next = MODE_CODE;
          if (is_quote) begin
            mode_next      = MODE_QUOTE;
            quote_dbl_next = (c == CH_DQUOTE);
          end
        end
      end
    endcase
  end

  assign q_push        = accept && emit;
  assign q_entry.pair  = pair;
  assign q_entry.data  = c;

  // Scanner state
  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= MODE_CODE;
      quote_dbl <= 1'b0;
    end else if (accept) begin
      mode      <= mode_next;
      quote_dbl <= quote_dbl_next;
    end
  end

endmodule

@@ sv/ccs_fifo.sv @@
// ccs_fifo: short request queue between scanner and output stage.
// Depends on ccs_pkg.
module ccs_fifo (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  ccs_pkg::ccs_entry_t push_entry,
  input  logic                pop,
  output ccs_pkg::ccs_entry_t head,
  output ccs_pkg::ccs_qstat_t qstat
);
  import ccs_pkg::*;

  ccs_entry_t        entries [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QCNT_W-1:0] count;

  assign head           = entries[rd_ptr];
  assign qstat.full     = (count == QCNT_W'(QDEPTH));
  assign qstat.nonempty = (count != '0);

  // Storage, no reset needed
  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_entry;
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

endmodule

@@ sv/ccs_back.sv @@
// ccs_back: output stage; expands queued requests into result bytes.
// Depends on ccs_pkg and ccs_out_if.
module ccs_back (
  input  logic                clk,
  input  logic                rst,
  input  ccs_pkg::ccs_entry_t head,
  input  ccs_pkg::ccs_qstat_t qstat,
  output logic                pop,
  ccs_out_if.source           dout
);
  import ccs_pkg::*;

  logic       out_valid;
  logic [7:0] out_byte;
  logic       out_last;
  logic       half;       // slash of a paired request already loaded
  logic       load;

  assign load = qstat.nonempty && (!out_valid || dout.ready);
  assign pop  = load && (!head.pair || half);

  assign dout.valid    = out_valid;
  assign dout.out_byte = out_byte;
  assign dout.last     = out_last;

  // Control: valid flag and pair progress
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      half      <= 1'b0;
    end else begin
      if (load)            out_valid <= 1'b1;
      else if (dout.ready) out_valid <= 1'b0;
      if (load) half <= head.pair && !half;
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (load) begin
      if (head.pair && !half) begin
        out_byte <= CH_SLASH;
        out_last <= 1'b0;
      end else begin
        out_byte <= head.data;
        out_last <= 1'b1;
      end
    end
  end

endmodule
